// ===== rtl/tmse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmse_pkg
// Shared sizes, command and status codes and the controller/datapath
// interface types of the Turing machine step engine.
// ----------------------------------------------------------------------------
package tmse_pkg;

  localparam int RULE_SLOTS     = 64;
  localparam int TAPE_CELLS     = 1024;
  localparam int SYMBOL_BITS    = 8;
  localparam int STATE_BITS     = 8;
  localparam int RULE_IDX_BITS  = $clog2(RULE_SLOTS);
  localparam int TAPE_ADDR_BITS = $clog2(TAPE_CELLS);
  localparam int CMD_BITS       = 3;
  localparam int STATUS_BITS    = 2;
  localparam int CFG_IDX_BITS   = 1;

  // command codes
  typedef enum logic [CMD_BITS-1:0] {
    CMD_LOAD_RULE  = 3'd0,
    CMD_WRITE_CELL = 3'd1,
    CMD_READ_CELL  = 3'd2,
    CMD_START      = 3'd3,
    CMD_STEP       = 3'd4
  } cmd_t;

  // stop status codes
  typedef enum logic [STATUS_BITS-1:0] {
    STS_RUN       = 2'd0,
    STS_NO_RULE   = 2'd1,
    STS_OFF_LEFT  = 2'd2,
    STS_OFF_RIGHT = 2'd3
  } sts_t;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_INITIAL_STATE  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEFAULT_SYMBOL = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic clear_en;    // clearing sweep write
    logic accept;      // input transaction taken
    logic dispatch;    // run the simple commands, build match vector
    logic select;      // lowest matching slot
    logic exec;        // fire the selected rule
    logic load_out;    // move result into output register
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic                clear_done;
    logic [CMD_BITS-1:0] cmd;
    logic                stopped;
    logic                out_free;
  } sts_bus_t;

endpackage : tmse_pkg
`default_nettype wire

// ===== rtl/tmse_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmse_ctrl
// Sequencer: clearing sweep after reset, then accept / dispatch /
// select / exec (running steps only) / result for each transaction.
// ----------------------------------------------------------------------------
module tmse_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tmse_pkg::sts_bus_t sts,
  output tmse_pkg::ctl_t          ctl
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SELECT,
    S_EXEC,
    S_RESULT
  } state_t;

  state_t state_r;
  logic   step_run;

  assign in_stall = (state_r != S_IDLE);
  assign step_run = (sts.cmd == tmse_pkg::CMD_STEP) && !sts.stopped;

  always_comb begin
    ctl          = '0;
    ctl.clear_en = (state_r == S_CLEAR);
    ctl.accept   = (state_r == S_IDLE) && in_valid;
    ctl.dispatch = (state_r == S_DISPATCH);
    ctl.select   = (state_r == S_SELECT);
    ctl.exec     = (state_r == S_EXEC);
    ctl.load_out = (state_r == S_RESULT) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          if (sts.clear_done) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) state_r <= S_DISPATCH;
        end
        S_DISPATCH: begin
          state_r <= step_run ? S_SELECT : S_RESULT;
        end
        S_SELECT: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_RESULT;
        end
        S_RESULT: begin
          if (sts.out_free) state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule : tmse_ctrl
`default_nettype wire

// ===== rtl/tmse_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmse_dp
// Datapath: rule registers and matcher, tape memory with written marks,
// machine state, configuration registers and result register.
// ----------------------------------------------------------------------------
module tmse_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire tmse_pkg::ctl_t                       ctl,
  output tmse_pkg::sts_bus_t                        sts,
  input  wire logic                                 cfg_valid,
  input  wire logic                                 cfg_ready,
  input  wire logic [tmse_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [7:0]                           cfg_data,
  input  wire logic [tmse_pkg::CMD_BITS-1:0]        in_command,
  input  wire logic [tmse_pkg::RULE_IDX_BITS-1:0]   in_rule_index,
  input  wire logic                                 in_rule_enable,
  input  wire logic [tmse_pkg::STATE_BITS-1:0]      in_match_state,
  input  wire logic [tmse_pkg::SYMBOL_BITS-1:0]     in_match_symbol,
  input  wire logic [tmse_pkg::SYMBOL_BITS-1:0]     in_write_symbol,
  input  wire logic                                 in_move_left,
  input  wire logic [tmse_pkg::STATE_BITS-1:0]      in_next_state,
  input  wire logic [tmse_pkg::TAPE_ADDR_BITS-1:0]  in_tape_address,
  input  wire logic [tmse_pkg::SYMBOL_BITS-1:0]     in_tape_symbol,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [tmse_pkg::STATUS_BITS-1:0]          out_status,
  output logic                                      out_halted,
  output logic [tmse_pkg::STATE_BITS-1:0]           out_current_state,
  output logic [tmse_pkg::TAPE_ADDR_BITS-1:0]       out_head_position,
  output logic [tmse_pkg::SYMBOL_BITS-1:0]          out_symbol
);

  localparam int SB = tmse_pkg::SYMBOL_BITS;
  localparam int TB = tmse_pkg::STATE_BITS;
  localparam int AB = tmse_pkg::TAPE_ADDR_BITS;
  localparam int NR = tmse_pkg::RULE_SLOTS;
  localparam logic [AB-1:0] LAST_CELL = AB'(tmse_pkg::TAPE_CELLS - 1);

  typedef struct packed {
    logic [TB-1:0] st;
    logic [SB-1:0] sym;
    logic [SB-1:0] wsym;
    logic          left;
    logic [TB-1:0] nst;
  } rule_t;

  localparam int RB = $bits(rule_t);

  typedef struct packed {
    logic [tmse_pkg::CMD_BITS-1:0]      cmd;
    logic [tmse_pkg::RULE_IDX_BITS-1:0] idx;
    logic                               en;
    rule_t                              rule;
    logic [AB-1:0]                      addr;
    logic [SB-1:0]                      tsym;
  } item_t;

  // tape memory: MSB is the written mark
  logic [SB:0]   tape_mem [tmse_pkg::TAPE_CELLS];
  logic [SB:0]   rdata_r;
  logic          mem_we;
  logic [AB-1:0] mem_waddr;
  logic [SB:0]   mem_wdata;
  logic [AB-1:0] mem_raddr;
  logic [AB-1:0] clr_addr_r;

  logic [RB-1:0] rule_r       [NR];
  logic [NR-1:0] rule_valid_r;
  logic [NR-1:0] hit_r;
  logic [NR-1:0] onehot_r;
  logic          any_r;
  logic [NR-1:0] hit_nxt;
  logic [RB-1:0] sel_bits;
  rule_t         sel_rule;

  item_t         item_r;
  logic [TB-1:0] init_state_r;
  logic [SB-1:0] dflt_sym_r;
  logic [TB-1:0] mstate_r;
  logic [AB-1:0] head_r;
  logic          stopped_r;
  logic [tmse_pkg::STATUS_BITS-1:0] stop_sts_r;
  logic [SB-1:0] sym_r;
  logic [SB-1:0] cur_sym;
  logic          out_valid_r;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_state_r <= '0;
      dflt_sym_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tmse_pkg::CFG_INITIAL_STATE:  init_state_r <= cfg_data[TB-1:0];
        tmse_pkg::CFG_DEFAULT_SYMBOL: dflt_sym_r   <= cfg_data[SB-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- tape memory ----------------
  assign mem_raddr = (in_command == tmse_pkg::CMD_STEP) ? head_r : in_tape_address;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = '0;
    if (ctl.clear_en) begin
      mem_we = 1'b1;
    end else if (ctl.dispatch && item_r.cmd == tmse_pkg::CMD_WRITE_CELL) begin
      mem_we    = 1'b1;
      mem_waddr = item_r.addr;
      mem_wdata = {1'b1, item_r.tsym};
    end else if (ctl.exec && any_r) begin
      mem_we    = 1'b1;
      mem_waddr = head_r;
      mem_wdata = {1'b1, sel_rule.wsym};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) tape_mem[mem_waddr] <= mem_wdata;
    if (ctl.accept) rdata_r <= tape_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (ctl.clear_en && clr_addr_r != LAST_CELL) begin
      clr_addr_r <= clr_addr_r + AB'(1);
    end
  end

  // unwritten cells read as the blank symbol
  assign cur_sym = rdata_r[SB] ? rdata_r[SB-1:0] : dflt_sym_r;

  // ---------------- item register ----------------
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      item_r.cmd       <= in_command;
      item_r.idx       <= in_rule_index;
      item_r.en        <= in_rule_enable;
      item_r.rule.st   <= in_match_state;
      item_r.rule.sym  <= in_match_symbol;
      item_r.rule.wsym <= in_write_symbol;
      item_r.rule.left <= in_move_left;
      item_r.rule.nst  <= in_next_state;
      item_r.addr      <= in_tape_address;
      item_r.tsym      <= in_tape_symbol;
    end
  end

  // ---------------- rule store and matcher ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_valid_r <= '0;
    end else if (ctl.dispatch && item_r.cmd == tmse_pkg::CMD_LOAD_RULE) begin
      rule_valid_r[item_r.idx] <= item_r.en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.dispatch && item_r.cmd == tmse_pkg::CMD_LOAD_RULE) begin
      rule_r[item_r.idx] <= item_r.rule;
    end
  end

  always_comb begin
    rule_t r;
    for (int i = 0; i < NR; i++) begin
      r          = rule_t'(rule_r[i]);
      hit_nxt[i] = rule_valid_r[i] && (r.st == mstate_r) && (r.sym == cur_sym);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.dispatch) hit_r <= hit_nxt;
    if (ctl.select) begin
      // isolate the lowest set bit
      onehot_r <= hit_r & (~hit_r + {{(NR-1){1'b0}}, 1'b1});
      any_r    <= |hit_r;
    end
  end

  always_comb begin
    sel_bits = '0;
    for (int i = 0; i < NR; i++) begin
      sel_bits = sel_bits | ({RB{onehot_r[i]}} & rule_r[i]);
    end
  end

  assign sel_rule = rule_t'(sel_bits);

  // ---------------- machine state ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mstate_r   <= '0;
      head_r     <= '0;
      stopped_r  <= 1'b0;
      stop_sts_r <= tmse_pkg::STS_RUN;
    end else if (ctl.dispatch && item_r.cmd == tmse_pkg::CMD_START) begin
      mstate_r   <= init_state_r;
      head_r     <= '0;
      stopped_r  <= 1'b0;
      stop_sts_r <= tmse_pkg::STS_RUN;
    end else if (ctl.exec) begin
      if (!any_r) begin
        stopped_r  <= 1'b1;
        stop_sts_r <= tmse_pkg::STS_NO_RULE;
      end else begin
        mstate_r <= sel_rule.nst;
        if (sel_rule.left) begin
          if (head_r == '0) begin
            stopped_r  <= 1'b1;
            stop_sts_r <= tmse_pkg::STS_OFF_LEFT;
          end else begin
            head_r <= head_r - AB'(1);
          end
        end else begin
          if (head_r == LAST_CELL) begin
            stopped_r  <= 1'b1;
            stop_sts_r <= tmse_pkg::STS_OFF_RIGHT;
          end else begin
            head_r <= head_r + AB'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.dispatch) begin
      sym_r <= (item_r.cmd == tmse_pkg::CMD_READ_CELL) ? cur_sym : '0;
    end else if (ctl.exec) begin
      sym_r <= any_r ? sel_rule.wsym : '0;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_status        <= stop_sts_r;
      out_halted        <= stopped_r;
      out_current_state <= mstate_r;
      out_head_position <= head_r;
      out_symbol        <= sym_r;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    sts            = '0;
    sts.clear_done = (clr_addr_r == LAST_CELL);
    sts.cmd        = item_r.cmd;
    sts.stopped    = stopped_r;
    sts.out_free   = !out_valid_r || !out_stall;
  end

endmodule : tmse_dp
`default_nettype wire

// ===== rtl/turing_machine_step_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// turing_machine_step_engine
// Single-tape Turing machine: rule slots, tape memory, start and step.
// Each transaction runs DISPATCH then RESULT; a running step adds SELECT and
//   EXEC between them, while other commands and halted steps skip both.
// A new transaction is taken only after the last result is loaded for output;
//   the step chain (tape read, rule match, lowest-slot select, fire) is longest.
// Reset: a sweep over every tape cell clears the written marks; in_stall stays
//   high meanwhile, configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module turing_machine_step_engine (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tmse_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [7:0]                          cfg_data,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [tmse_pkg::CMD_BITS-1:0]       in_command,
  input  wire logic [tmse_pkg::RULE_IDX_BITS-1:0]  in_rule_index,
  input  wire logic                                in_rule_enable,
  input  wire logic [tmse_pkg::STATE_BITS-1:0]     in_match_state,
  input  wire logic [tmse_pkg::SYMBOL_BITS-1:0]    in_match_symbol,
  input  wire logic [tmse_pkg::SYMBOL_BITS-1:0]    in_write_symbol,
  input  wire logic                                in_move_left,
  input  wire logic [tmse_pkg::STATE_BITS-1:0]     in_next_state,
  input  wire logic [tmse_pkg::TAPE_ADDR_BITS-1:0] in_tape_address,
  input  wire logic [tmse_pkg::SYMBOL_BITS-1:0]    in_tape_symbol,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [tmse_pkg::STATUS_BITS-1:0]         out_status,
  output logic                                     out_halted,
  output logic [tmse_pkg::STATE_BITS-1:0]          out_current_state,
  output logic [tmse_pkg::TAPE_ADDR_BITS-1:0]      out_head_position,
  output logic [tmse_pkg::SYMBOL_BITS-1:0]         out_symbol
);

  tmse_pkg::ctl_t     ctl;
  tmse_pkg::sts_bus_t sts;

  // Configuration registers live in the datapath, may be written any cycle and
  // are unchecked; software must write them only while no transaction is in flight.
  assign cfg_ready = 1'b1;

  // Controller: clearing sweep, then per transaction
  //   IDLE -> DISPATCH -> [SELECT -> EXEC] -> RESULT -> IDLE.
  // RESULT waits until the output register is free, so a finished result
  // parked on a stalled output never gets overwritten.
  tmse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Datapath: tape memory (one write, one registered read port), rule
  // registers with a 64-way match, lowest-slot one-hot select, head/state
  // update and the output register.
  tmse_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .sts               (sts),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_command        (in_command),
    .in_rule_index     (in_rule_index),
    .in_rule_enable    (in_rule_enable),
    .in_match_state    (in_match_state),
    .in_match_symbol   (in_match_symbol),
    .in_write_symbol   (in_write_symbol),
    .in_move_left      (in_move_left),
    .in_next_state     (in_next_state),
    .in_tape_address   (in_tape_address),
    .in_tape_symbol    (in_tape_symbol),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_halted        (out_halted),
    .out_current_state (out_current_state),
    .out_head_position (out_head_position),
    .out_symbol        (out_symbol)
  );

endmodule : turing_machine_step_engine
`default_nettype wire

// ===== tb/sv/turing_machine_step_engine_test.sv =====
// ----------------------------------------------------------------------------
// turing_machine_step_engine_test
// Self-checking bench for the Turing machine step engine. A predictor runs
// beside the block and mirrors its rule slots, tape, written marks, head,
// state and halt status. Every input transaction goes through that predictor
// when it is accepted. Each result transaction is checked against the oldest
// prediction still waiting. Stimulus: directed rule, halt and register cases,
// random machine programs (rules, seeded tape, start, step runs, read-back)
// with noise, and a walk off the right end of the tape.
// ----------------------------------------------------------------------------
module turing_machine_step_engine_test;
  import tmse_pkg::*;

  typedef logic [STATE_BITS-1:0]     state_id_t;
  typedef logic [SYMBOL_BITS-1:0]    symbol_t;
  typedef logic [TAPE_ADDR_BITS-1:0] cell_addr_t;
  typedef logic [RULE_IDX_BITS-1:0]  slot_t;
  typedef logic [CMD_BITS-1:0]       cmd_code_t;

  // codes above CMD_STEP are unused; the block only reports its status
  localparam int        CMD_CODE_MAX     = (1 << CMD_BITS) - 1;
  localparam cmd_code_t CMD_UNUSED_FIRST = cmd_code_t'(int'(CMD_STEP) + 1);
  localparam cmd_code_t CMD_UNUSED_LAST  = cmd_code_t'(CMD_CODE_MAX);
  localparam cell_addr_t LAST_CELL       = cell_addr_t'(TAPE_CELLS - 1);

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int          MAX_SHOWN   = 10;
  localparam int          TAIL_CYCLES = 8;

  // one input transaction
  typedef struct {
    cmd_code_t  command;
    slot_t      rule_index;
    logic       rule_enable;
    state_id_t  match_state;
    symbol_t    match_symbol;
    symbol_t    write_symbol;
    logic       move_left;
    state_id_t  next_state;
    cell_addr_t tape_address;
    symbol_t    tape_symbol;
  } tm_request_t;

  // one result transaction
  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic                   halted;
    state_id_t              state;
    cell_addr_t             head;
    symbol_t                symbol;
  } tm_report_t;

  typedef struct {
    bit                   valid;
    bit [STATE_BITS-1:0]  st;
    bit [SYMBOL_BITS-1:0] sym;
    bit [SYMBOL_BITS-1:0] wsym;
    bit                   left;
    bit [STATE_BITS-1:0]  nst;
  } tm_rule_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input has a known value from time 0
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [7:0]              cfg_data  = '0;

  logic       in_valid        = 1'b0;
  logic       in_stall;
  cmd_code_t  in_command      = '0;
  slot_t      in_rule_index   = '0;
  logic       in_rule_enable  = 1'b0;
  state_id_t  in_match_state  = '0;
  symbol_t    in_match_symbol = '0;
  symbol_t    in_write_symbol = '0;
  logic       in_move_left    = 1'b0;
  state_id_t  in_next_state   = '0;
  cell_addr_t in_tape_address = '0;
  symbol_t    in_tape_symbol  = '0;

  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [STATUS_BITS-1:0] out_status;
  logic                   out_halted;
  state_id_t              out_current_state;
  cell_addr_t             out_head_position;
  symbol_t                out_symbol;

  turing_machine_step_engine u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_rule_index     (in_rule_index),
    .in_rule_enable    (in_rule_enable),
    .in_match_state    (in_match_state),
    .in_match_symbol   (in_match_symbol),
    .in_write_symbol   (in_write_symbol),
    .in_move_left      (in_move_left),
    .in_next_state     (in_next_state),
    .in_tape_address   (in_tape_address),
    .in_tape_symbol    (in_tape_symbol),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_halted        (out_halted),
    .out_current_state (out_current_state),
    .out_head_position (out_head_position),
    .out_symbol        (out_symbol)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of everything the block remembers
  // --------------------------------------------------------------------------
  tm_rule_t             rule_slots   [RULE_SLOTS];
  bit [SYMBOL_BITS-1:0] tape_sym     [TAPE_CELLS];
  bit                   tape_written [TAPE_CELLS];
  state_id_t            tm_state     = '0;
  cell_addr_t           tm_head      = '0;
  logic                 tm_halted    = 1'b0;
  sts_t                 tm_status    = STS_RUN;
  state_id_t            init_state   = '0;
  symbol_t              blank_sym    = '0;

  tm_report_t  reports_due [$];   // predicted results, oldest first
  int          requests_sent = 0; // accepted transactions with a real command
  int          fail_count    = 0;
  int          idle_pct      = 0; // sender idle chance per cycle, percent
  int          stall_pct     = 0; // receiver stall chance per cycle, percent
  int unsigned cycle_count   = 0;
  tm_report_t  got_report;
  tm_report_t  want_report;

  // unwritten cells read as the blank symbol
  function automatic symbol_t cell_value(input cell_addr_t addr);
    return tape_written[addr] ? symbol_t'(tape_sym[addr]) : blank_sym;
  endfunction

  // Apply one accepted command to the predictor and return the result the
  // block must report for it.
  function automatic tm_report_t run_command(input tm_request_t rq);
    tm_report_t rp;
    symbol_t    under;
    int         hit;
    rp.symbol = '0;
    case (rq.command)
      CMD_LOAD_RULE: begin
        rule_slots[rq.rule_index].valid = rq.rule_enable;
        rule_slots[rq.rule_index].st    = rq.match_state;
        rule_slots[rq.rule_index].sym   = rq.match_symbol;
        rule_slots[rq.rule_index].wsym  = rq.write_symbol;
        rule_slots[rq.rule_index].left  = rq.move_left;
        rule_slots[rq.rule_index].nst   = rq.next_state;
      end
      CMD_WRITE_CELL: begin
        tape_sym[rq.tape_address]     = rq.tape_symbol;
        tape_written[rq.tape_address] = 1'b1;
      end
      CMD_READ_CELL: begin
        rp.symbol = cell_value(rq.tape_address);
      end
      CMD_START: begin
        // rules and tape survive a start
        tm_head   = '0;
        tm_state  = init_state;
        tm_halted = 1'b0;
        tm_status = STS_RUN;
      end
      CMD_STEP: begin
        // a halted machine ignores steps and reports symbol 0
        if (!tm_halted) begin
          under = cell_value(tm_head);
          hit   = -1;
          // scan from the top so the lowest matching slot wins
          for (int i = RULE_SLOTS - 1; i >= 0; i--) begin
            if (rule_slots[i].valid && rule_slots[i].st == tm_state &&
                rule_slots[i].sym == under) begin
              hit = i;
            end
          end
          if (hit < 0) begin
            tm_halted = 1'b1;
            tm_status = STS_NO_RULE;
          end else begin
            tape_sym[tm_head]     = rule_slots[hit].wsym;
            tape_written[tm_head] = 1'b1;
            tm_state              = rule_slots[hit].nst;
            rp.symbol             = rule_slots[hit].wsym;
            // at either end the write and state change stand, the head stays
            if (rule_slots[hit].left) begin
              if (tm_head == '0) begin
                tm_halted = 1'b1;
                tm_status = STS_OFF_LEFT;
              end else begin
                tm_head = tm_head - cell_addr_t'(1);
              end
            end else if (tm_head == LAST_CELL) begin
              tm_halted = 1'b1;
              tm_status = STS_OFF_RIGHT;
            end else begin
              tm_head = tm_head + cell_addr_t'(1);
            end
          end
        end
      end
      default: ;
    endcase
    rp.status = tm_status;
    rp.halted = tm_halted;
    rp.state  = tm_state;
    rp.head   = tm_head;
    return rp;
  endfunction

  // --------------------------------------------------------------------------
  // Transaction builders: fields the command does not use carry random junk
  // --------------------------------------------------------------------------
  function automatic tm_request_t noise_request();
    tm_request_t rq;
    rq.command      = cmd_code_t'($urandom_range(CMD_CODE_MAX));
    rq.rule_index   = slot_t'($urandom_range(RULE_SLOTS - 1));
    rq.rule_enable  = 1'($urandom_range(1));
    rq.match_state  = state_id_t'($urandom);
    rq.match_symbol = symbol_t'($urandom);
    rq.write_symbol = symbol_t'($urandom);
    rq.move_left    = 1'($urandom_range(1));
    rq.next_state   = state_id_t'($urandom);
    rq.tape_address = cell_addr_t'($urandom_range(TAPE_CELLS - 1));
    rq.tape_symbol  = symbol_t'($urandom);
    return rq;
  endfunction

  function automatic tm_request_t rule_request(input slot_t idx, input logic en,
                                               input state_id_t st, input symbol_t sym,
                                               input symbol_t wsym, input logic left,
                                               input state_id_t nst);
    tm_request_t rq;
    rq              = noise_request();
    rq.command      = CMD_LOAD_RULE;
    rq.rule_index   = idx;
    rq.rule_enable  = en;
    rq.match_state  = st;
    rq.match_symbol = sym;
    rq.write_symbol = wsym;
    rq.move_left    = left;
    rq.next_state   = nst;
    return rq;
  endfunction

  function automatic tm_request_t cell_request(input cmd_code_t cmd, input cell_addr_t addr,
                                               input symbol_t sym);
    tm_request_t rq;
    rq              = noise_request();
    rq.command      = cmd;
    rq.tape_address = addr;
    rq.tape_symbol  = sym;
    return rq;
  endfunction

  function automatic tm_request_t ctl_request(input cmd_code_t cmd);
    tm_request_t rq;
    rq         = noise_request();
    rq.command = cmd;
    return rq;
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Drives at the rising edge; the handshake is judged on the values
  // seen just before the edge. Callers either send again or drain right
  // after a return, so a held valid never repeats a transaction.
  // --------------------------------------------------------------------------
  task automatic send_request(input tm_request_t rq);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= rq.command;
    in_rule_index   <= rq.rule_index;
    in_rule_enable  <= rq.rule_enable;
    in_match_state  <= rq.match_state;
    in_match_symbol <= rq.match_symbol;
    in_write_symbol <= rq.write_symbol;
    in_move_left    <= rq.move_left;
    in_next_state   <= rq.next_state;
    in_tape_address <= rq.tape_address;
    in_tape_symbol  <= rq.tape_symbol;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    reports_due.push_back(run_command(rq));
    if (rq.command <= CMD_STEP) requests_sent++;
  endtask

  // stop sending and wait for every predicted result
  task automatic drain_reports();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
  endtask

  // write both registers back to back; only called with the block idle
  task automatic program_regs(input state_id_t init_val, input symbol_t blank_val);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_INITIAL_STATE;
    cfg_data  <= init_val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_index <= CFG_DEFAULT_SYMBOL;
    cfg_data  <= blank_val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid  <= 1'b0;
    init_state = init_val;
    blank_sym  = blank_val;
  endtask

  // --------------------------------------------------------------------------
  // Result checker and receiver stall
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got_report = {out_status, out_halted, out_current_state, out_head_position,
                    out_symbol};
      if (reports_due.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN) begin
          $display("unexpected result transaction: status %0d halted %0d state %0h head %0d symbol %0h",
                   got_report.status, got_report.halted, got_report.state,
                   got_report.head, got_report.symbol);
        end
      end else begin
        want_report = reports_due.pop_front();
        if (got_report.status !== want_report.status ||
            got_report.halted !== want_report.halted ||
            got_report.state  !== want_report.state ||
            got_report.head   !== want_report.head ||
            got_report.symbol !== want_report.symbol) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN) begin
            $display("mismatch: expected status %0d halted %0d state %0h head %0d symbol %0h",
                     want_report.status, want_report.halted, want_report.state,
                     want_report.head, want_report.symbol);
            $display("          actual   status %0d halted %0d state %0h head %0d symbol %0h",
                     got_report.status, got_report.halted, got_report.state,
                     got_report.head, got_report.symbol);
          end
        end
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Zero registers. Disabled slot, step before start, no matching rule,
  // step while halted, blank reads, unused codes, left edge, slot priority.
  task automatic test_rules_and_halts();
    program_regs(8'h00, 8'h00);
    send_request(rule_request(6'd0, 1'b0, 8'h00, 8'h00, 8'hAA, 1'b1, 8'h01));
    send_request(rule_request(6'd63, 1'b1, 8'h00, 8'h00, 8'hFF, 1'b0, 8'hFF));
    // runs from the reset state and head; only slot 63 is live
    send_request(ctl_request(CMD_STEP));
    send_request(ctl_request(CMD_STEP));                    // nothing for state FF
    send_request(ctl_request(CMD_STEP));                    // halted: no change
    send_request(cell_request(CMD_READ_CELL, 10'd0, 8'h00));
    send_request(cell_request(CMD_WRITE_CELL, 10'd1023, 8'hFF));
    send_request(cell_request(CMD_READ_CELL, 10'd1023, 8'h00));
    send_request(cell_request(CMD_READ_CELL, 10'd512, 8'h00)); // never written
    send_request(ctl_request(CMD_UNUSED_FIRST));
    send_request(ctl_request(CMD_UNUSED_LAST));
    send_request(ctl_request(CMD_START));
    // cell 0 holds FF now; a left move there halts after the write
    send_request(rule_request(6'd1, 1'b1, 8'h00, 8'hFF, 8'h00, 1'b1, 8'h00));
    send_request(ctl_request(CMD_STEP));
    send_request(ctl_request(CMD_STEP));
    send_request(ctl_request(CMD_START));
    send_request(cell_request(CMD_WRITE_CELL, 10'd0, 8'h00));
    // slots 2 and 63 both match state 0 on symbol 0: slot 2 must fire
    send_request(rule_request(6'd2, 1'b1, 8'h00, 8'h00, 8'h55, 1'b0, 8'h00));
    send_request(ctl_request(CMD_STEP));
    send_request(ctl_request(CMD_STEP));
    send_request(cell_request(CMD_READ_CELL, 10'd1, 8'h00));
  endtask

  // Both registers at their top value; start takes the new initial state.
  task automatic test_high_register_values();
    drain_reports();
    program_regs(8'hFF, 8'hFF);
    send_request(ctl_request(CMD_START));
    send_request(cell_request(CMD_READ_CELL, 10'd700, 8'h00));
    send_request(rule_request(6'd3, 1'b1, 8'hFF, 8'h55, 8'h0F, 1'b0, 8'hAA));
    send_request(ctl_request(CMD_STEP));
    send_request(ctl_request(CMD_STEP));
  endtask

  // One small random machine: rules over a few states and symbols, a seeded
  // tape, start, a run of steps, then a read-back. The blank symbol is always
  // in the pool so the machine keeps going on fresh cells.
  task automatic run_random_program();
    state_id_t states [4];
    symbol_t   syms [3];
    int        n_st;
    int        n_sy;
    int        base;
    int        k;
    int        steps;
    n_st      = $urandom_range(4, 1);
    n_sy      = $urandom_range(3, 2);
    states[0] = init_state;
    syms[0]   = blank_sym;
    for (int i = 1; i < 4; i++) states[i] = state_id_t'($urandom);
    for (int i = 1; i < 3; i++) syms[i] = symbol_t'($urandom);
    base = $urandom_range(RULE_SLOTS - 1);
    k    = 0;
    for (int s = 0; s < n_st; s++) begin
      for (int y = 0; y < n_sy; y++) begin
        if ($urandom_range(9) == 0) send_request(noise_request());
        // an occasional missing pair gives a no-rule halt
        if ($urandom_range(9) != 0) begin
          send_request(rule_request(slot_t'((base + k) % RULE_SLOTS), 1'b1,
                                    states[s], syms[y], syms[$urandom_range(n_sy - 1)],
                                    1'($urandom_range(9) < 4),
                                    states[$urandom_range(n_st - 1)]));
          k++;
        end
        // clearing a slot, sometimes one of this program's own
        if ($urandom_range(19) == 0) begin
          send_request(rule_request(slot_t'((base + $urandom_range(k)) % RULE_SLOTS),
                                    1'b0, states[s], syms[y], symbol_t'($urandom),
                                    1'($urandom_range(1)), state_id_t'($urandom)));
        end
      end
    end
    repeat ($urandom_range(4)) begin
      send_request(cell_request(CMD_WRITE_CELL, cell_addr_t'($urandom_range(7)),
                                syms[$urandom_range(n_sy - 1)]));
    end
    send_request(ctl_request(CMD_START));
    steps = $urandom_range(40, 4);
    while (steps > 0 && !tm_halted) begin
      if ($urandom_range(19) == 0) send_request(noise_request());
      send_request(ctl_request(CMD_STEP));
      steps--;
    end
    if ($urandom_range(1) == 1) send_request(ctl_request(CMD_STEP));
    repeat ($urandom_range(3, 1)) begin
      if ($urandom_range(3) == 0) begin
        send_request(cell_request(CMD_READ_CELL, cell_addr_t'($urandom_range(TAPE_CELLS - 1)),
                                  symbol_t'($urandom)));
      end else begin
        send_request(cell_request(CMD_READ_CELL, cell_addr_t'($urandom_range(15)),
                                  symbol_t'($urandom)));
      end
    end
  endtask

  // A phase of random programs under one idling mix and fresh registers.
  task automatic test_random_programs(input int sender_idle, input int receiver_stall,
                                      input int count);
    int stop_at;
    drain_reports();
    program_regs(state_id_t'($urandom), symbol_t'($urandom));
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    stop_at   = requests_sent + count;
    while (requests_sent < stop_at) run_random_program();
  endtask

  // Walk right across the whole tape until the head hits the last cell.
  // Cells left by earlier tests are first reset to the blank symbol so the
  // single rule in slot 0 fires on every cell.
  task automatic test_right_edge_walk();
    state_id_t walker;
    drain_reports();
    walker = state_id_t'($urandom);
    program_regs(walker, symbol_t'($urandom));
    idle_pct  = 11;
    stall_pct = 11;
    for (int a = 0; a < TAPE_CELLS; a++) begin
      if (tape_written[a] && symbol_t'(tape_sym[a]) != blank_sym) begin
        send_request(cell_request(CMD_WRITE_CELL, cell_addr_t'(a), blank_sym));
      end
    end
    send_request(rule_request('0, 1'b1, walker, blank_sym, symbol_t'($urandom), 1'b0,
                              walker));
    send_request(ctl_request(CMD_START));
    while (!tm_halted) send_request(ctl_request(CMD_STEP));
    send_request(ctl_request(CMD_STEP));
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_rules_and_halts();
    test_high_register_values();
    test_random_programs(0, 0, 163);
    test_random_programs(53, 0, 163);
    test_random_programs(0, 53, 163);
    test_random_programs(11, 11, 163);
    test_right_edge_walk();
    drain_reports();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tmse_pkg.sv
rtl/tmse_ctrl.sv
rtl/tmse_dp.sv
rtl/turing_machine_step_engine.sv
tb/sv/turing_machine_step_engine_test.sv
